[rtl/cbht_pkg.sv]
// Shared widths, control codes and control structs for the cubic Bezier hit test.
`timescale 1ns / 1ps

package cbht_pkg;

  // Forward-difference registers; every sample offset fits well inside this width.
  localparam int DW     = 50;
  // Squared-distance accumulator width.
  localparam int AW     = 94;
  // Magnitude of one offset, split into a high and a low half for squaring.
  localparam int MW     = 47;
  localparam int LW     = 23;
  // Shared multiplier operand and product widths.
  localparam int MAW    = 32;
  localparam int MBW    = 24;
  localparam int PW     = MAW + MBW;
  // Cubic coefficient of one coordinate.
  localparam int A3W    = 20;
  // Step counter inside the setup and sample sequences.
  localparam int STEP_W = 4;
  // Alignment of the partial products of a square.
  localparam int SH_HH  = 2 * LW;
  localparam int SH_HL  = LW + 1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SETUP  = 3'b010,
    S_SAMPLE = 3'b100
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_BX,
    MUL_CX,
    MUL_EX,
    MUL_BY,
    MUL_CY,
    MUL_EY,
    MUL_TOL,
    MUL_HH,
    MUL_HL,
    MUL_LL
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_HH,
    ACC_HL,
    ACC_LL
  } acc_sel_t;

  typedef enum logic [1:0] {
    MAG_HOLD,
    MAG_PROD,
    MAG_DX,
    MAG_DY
  } mag_sel_t;

  typedef struct packed {
    logic ld_c2;
    logic ld_c1;
    logic ld_c0;
    logic adv;
  } diff_ctl_t;

  typedef struct packed {
    logic      take;
    mul_sel_t  mul_sel;
    acc_sel_t  acc_sel;
    mag_sel_t  mag_sel;
    diff_ctl_t diff_x;
    diff_ctl_t diff_y;
    logic      lim_ld;
    logic      res_ld;
  } seq_ctl_t;

endpackage

[rtl/cbht_mul.sv]
// Shared registered multiplier: unsigned 32 by 24 bits, with a sign flag carried alongside.
`timescale 1ns / 1ps

module cbht_mul
  import cbht_pkg::*;
(
  input  logic           clk,
  input  logic [MAW-1:0] a,
  input  logic [MBW-1:0] b,
  input  logic           neg,
  output logic [PW-1:0]  prod,
  output logic           prod_neg
);

  always_ff @(posedge clk) begin
    prod     <= PW'(a) * PW'(b);
    prod_neg <= neg;
  end

endmodule

[rtl/cbht_diff.sv]
// Forward-difference engine for one coordinate of the sample offset from the query point.
`timescale 1ns / 1ps

module cbht_diff
  import cbht_pkg::*;
(
  input  logic                  clk,
  input  diff_ctl_t             ctl,
  input  logic signed [A3W-1:0] a3,
  input  logic signed [DW-1:0]  prod_val,
  output logic signed [DW-1:0]  d
);

  logic signed [DW-1:0] c2;
  logic signed [DW-1:0] d1;
  logic signed [DW-1:0] d2;
  logic signed [DW-1:0] d3;
  logic signed [DW-1:0] a3_ext;
  logic signed [DW-1:0] a3_six;

  assign a3_ext = DW'(a3);
  assign a3_six = (a3_ext <<< 2) + (a3_ext <<< 1);

  // The offset is a cubic in the sample index, so three running differences
  // step it exactly; wrap-around in the upper bits cancels out.
  always_ff @(posedge clk) begin
    if (ctl.ld_c2) begin
      c2 <= prod_val;
    end
    if (ctl.ld_c1) begin
      d1 <= a3_ext + c2 + prod_val;
      d2 <= a3_six + (c2 <<< 1);
      d3 <= a3_six;
    end
    if (ctl.ld_c0) begin
      d <= prod_val;
    end
    if (ctl.adv) begin
      d  <= d + d1;
      d1 <= d1 + d2;
      d2 <= d2 + d3;
    end
  end

endmodule

[rtl/cbht_ctrl.sv]
// Sequencer: steps the shared multiplier through setup and through each curve sample.
`timescale 1ns / 1ps

module cbht_ctrl
  import cbht_pkg::*;
#(
  parameter int unsigned NUM_STEPS = 100
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     hit_cond,
  output seq_ctl_t ctl
);

  localparam int KW = $clog2(NUM_STEPS + 1);

  state_t              state;
  state_t              state_next;
  logic [STEP_W-1:0]   step;
  logic [STEP_W-1:0]   step_next;
  logic [KW-1:0]       k;
  logic [KW-1:0]       k_next;
  logic                out_valid_next;
  logic                last;
  logic                out_free;

  assign last     = (k == KW'(NUM_STEPS));
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl            = '0;
    state_next     = state;
    step_next      = step;
    k_next         = k;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.take    = 1'b1;
          ctl.acc_sel = ACC_CLEAR;
          state_next  = S_SETUP;
          step_next   = '0;
        end
      end
      S_SETUP: begin
        step_next = step + 1'b1;
        case (step)
          4'd0: ctl.mul_sel = MUL_BX;
          4'd1: begin
            ctl.mul_sel      = MUL_CX;
            ctl.diff_x.ld_c2 = 1'b1;
          end
          4'd2: begin
            ctl.mul_sel      = MUL_EX;
            ctl.diff_x.ld_c1 = 1'b1;
          end
          4'd3: begin
            ctl.mul_sel      = MUL_BY;
            ctl.diff_x.ld_c0 = 1'b1;
          end
          4'd4: begin
            ctl.mul_sel      = MUL_CY;
            ctl.diff_y.ld_c2 = 1'b1;
          end
          4'd5: begin
            ctl.mul_sel      = MUL_EY;
            ctl.diff_y.ld_c1 = 1'b1;
          end
          4'd6: begin
            ctl.mul_sel      = MUL_TOL;
            ctl.diff_y.ld_c0 = 1'b1;
          end
          4'd7: ctl.mag_sel = MAG_PROD;
          4'd8: ctl.mul_sel = MUL_HH;
          4'd9: begin
            ctl.mul_sel = MUL_HL;
            ctl.acc_sel = ACC_HH;
          end
          4'd10: begin
            ctl.mul_sel = MUL_LL;
            ctl.acc_sel = ACC_HL;
          end
          4'd11: ctl.acc_sel = ACC_LL;
          4'd12: begin
            ctl.lim_ld  = 1'b1;
            ctl.acc_sel = ACC_CLEAR;
            state_next  = S_SAMPLE;
            step_next   = '0;
            k_next      = '0;
          end
          default: begin
          end
        endcase
      end
      S_SAMPLE: begin
        step_next = step + 1'b1;
        case (step)
          4'd0: ctl.mag_sel = MAG_DX;
          4'd1: ctl.mul_sel = MUL_HH;
          4'd2: begin
            ctl.mul_sel = MUL_HL;
            ctl.acc_sel = ACC_HH;
          end
          4'd3: begin
            ctl.mul_sel = MUL_LL;
            ctl.acc_sel = ACC_HL;
            ctl.mag_sel = MAG_DY;
          end
          4'd4: begin
            ctl.mul_sel = MUL_HH;
            ctl.acc_sel = ACC_LL;
          end
          4'd5: begin
            ctl.mul_sel = MUL_HL;
            ctl.acc_sel = ACC_HH;
          end
          4'd6: begin
            ctl.mul_sel = MUL_LL;
            ctl.acc_sel = ACC_HL;
          end
          4'd7: ctl.acc_sel = ACC_LL;
          4'd8: begin
            if (hit_cond || last) begin
              if (out_free) begin
                ctl.res_ld     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                step_next      = '0;
              end else begin
                step_next = step;
              end
            end else begin
              ctl.diff_x.adv = 1'b1;
              ctl.diff_y.adv = 1'b1;
              ctl.acc_sel    = ACC_CLEAR;
              k_next         = k + 1'b1;
              step_next      = '0;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/cubic_bezier_hit_test.sv]
// Top level of the cubic Bezier hit test: input registers, shared datapath and result register.
//
//   Channel  Handshake            Word carried
//   -------  -------------------  ---------------------------------------------------------
//   in       in_valid / in_ready  point, start, two control points, finish (x and y), tolerance
//   out      out_valid/out_ready  hit
//
// One word runs through a setup sequence, then through a sample sequence for each
// curve sample, and the sampling stops at the first sample found inside the
// tolerance or at sample NUM_STEPS. The pace is set by the single 32 by 24 bit
// multiplier, which forms the six partial products of the two squared offsets of
// every sample one after another. The block takes a new word only once the previous
// one has finished its samples. A finished result waits in the output register while
// the next word is worked on; should it still be waiting when the next result is
// ready, the last sample step holds until it is taken. rst clears the sequencer and
// the output valid.
//
// Each sample is kept scaled by NUM_STEPS cubed and stepped exactly by forward
// differences of its offset from the query point, so no rounding ever occurs.
`timescale 1ns / 1ps

module cubic_bezier_hit_test
  import cbht_pkg::*;
#(
  parameter int unsigned NUM_STEPS = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] first_ctrl_x,
  input  logic signed [15:0] first_ctrl_y,
  input  logic signed [15:0] second_ctrl_x,
  input  logic signed [15:0] second_ctrl_y,
  input  logic signed [15:0] finish_x,
  input  logic signed [15:0] finish_y,
  input  logic        [14:0] tolerance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit
);

  // Scale factors of the polynomial coefficients: 3N, 3 times N squared and N cubed.
  localparam logic [MAW-1:0] C3N  = MAW'(3 * NUM_STEPS);
  localparam logic [MAW-1:0] C3N2 = MAW'(3 * NUM_STEPS * NUM_STEPS);
  localparam logic [MAW-1:0] CN3  = MAW'(NUM_STEPS * NUM_STEPS * NUM_STEPS);

  function automatic logic [MBW-1:0] mag_b(input logic signed [MBW-1:0] v);
    logic signed [MBW-1:0] t;
    t = v[MBW-1] ? -v : v;
    return unsigned'(t);
  endfunction

  function automatic logic [MW-1:0] mag_d(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] t;
    t = v[DW-1] ? -v : v;
    return t[MW-1:0];
  endfunction

  seq_ctl_t ctl;
  logic     hit_cond;

  // Registered input word.
  logic signed [15:0] px_q;
  logic signed [15:0] py_q;
  logic signed [15:0] x0_q;
  logic signed [15:0] y0_q;
  logic signed [15:0] x1_q;
  logic signed [15:0] y1_q;
  logic signed [15:0] x2_q;
  logic signed [15:0] y2_q;
  logic signed [15:0] x3_q;
  logic signed [15:0] y3_q;
  logic        [14:0] tol_q;

  // Coordinate combinations that feed the coefficient products.
  logic signed [MBW-1:0] bx;
  logic signed [MBW-1:0] cx;
  logic signed [MBW-1:0] ex;
  logic signed [MBW-1:0] by;
  logic signed [MBW-1:0] cy;
  logic signed [MBW-1:0] ey;
  logic signed [A3W-1:0] a3x;
  logic signed [A3W-1:0] a3y;

  logic [MAW-1:0]       mul_a;
  logic [MBW-1:0]       mul_b;
  logic                 mul_neg;
  logic [PW-1:0]        prod;
  logic                 prod_neg;
  logic signed [DW-1:0] prod_mag;
  logic signed [DW-1:0] prod_val;

  logic [MW-1:0]        mag;
  logic [MBW-1:0]       mag_hi;
  logic [LW-1:0]        mag_lo;
  logic [AW-1:0]        acc;
  logic [AW-1:0]        acc_next;
  logic [AW-1:0]        limit;
  logic signed [DW-1:0] x_d;
  logic signed [DW-1:0] y_d;

  cbht_ctrl #(
    .NUM_STEPS(NUM_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit_cond (hit_cond),
    .ctl      (ctl)
  );

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      px_q  <= point_x;
      py_q  <= point_y;
      x0_q  <= start_x;
      y0_q  <= start_y;
      x1_q  <= first_ctrl_x;
      y1_q  <= first_ctrl_y;
      x2_q  <= second_ctrl_x;
      y2_q  <= second_ctrl_y;
      x3_q  <= finish_x;
      y3_q  <= finish_y;
      tol_q <= tolerance;
    end
  end

  // The offset of sample k from the query point is a3*k^3 + 3N*b*k^2
  // + 3N^2*c*k + N^3*e, with b = P0 - 2P1 + P2, c = P1 - P0 and e = P0 - Q.
  assign bx = MBW'(x0_q) - (MBW'(x1_q) <<< 1) + MBW'(x2_q);
  assign cx = MBW'(x1_q) - MBW'(x0_q);
  assign ex = MBW'(x0_q) - MBW'(px_q);
  assign by = MBW'(y0_q) - (MBW'(y1_q) <<< 1) + MBW'(y2_q);
  assign cy = MBW'(y1_q) - MBW'(y0_q);
  assign ey = MBW'(y0_q) - MBW'(py_q);

  assign a3x = (A3W'(x3_q) - A3W'(x0_q)) + ((A3W'(x1_q) - A3W'(x2_q)) <<< 1)
             + (A3W'(x1_q) - A3W'(x2_q));
  assign a3y = (A3W'(y3_q) - A3W'(y0_q)) + ((A3W'(y1_q) - A3W'(y2_q)) <<< 1)
             + (A3W'(y1_q) - A3W'(y2_q));

  assign mag_hi = mag[MW-1:LW];
  assign mag_lo = mag[LW-1:0];

  // The multiplier works on magnitudes; the sign travels with the product.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (ctl.mul_sel)
      MUL_BX: begin
        mul_a   = C3N;
        mul_b   = mag_b(bx);
        mul_neg = bx[MBW-1];
      end
      MUL_CX: begin
        mul_a   = C3N2;
        mul_b   = mag_b(cx);
        mul_neg = cx[MBW-1];
      end
      MUL_EX: begin
        mul_a   = CN3;
        mul_b   = mag_b(ex);
        mul_neg = ex[MBW-1];
      end
      MUL_BY: begin
        mul_a   = C3N;
        mul_b   = mag_b(by);
        mul_neg = by[MBW-1];
      end
      MUL_CY: begin
        mul_a   = C3N2;
        mul_b   = mag_b(cy);
        mul_neg = cy[MBW-1];
      end
      MUL_EY: begin
        mul_a   = CN3;
        mul_b   = mag_b(ey);
        mul_neg = ey[MBW-1];
      end
      MUL_TOL: begin
        mul_a = CN3;
        mul_b = MBW'(tol_q);
      end
      MUL_HH: begin
        mul_a = MAW'(mag_hi);
        mul_b = mag_hi;
      end
      MUL_HL: begin
        mul_a = MAW'(mag_hi);
        mul_b = MBW'(mag_lo);
      end
      MUL_LL: begin
        mul_a = MAW'(mag_lo);
        mul_b = MBW'(mag_lo);
      end
      default: begin
      end
    endcase
  end

  cbht_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .neg     (mul_neg),
    .prod    (prod),
    .prod_neg(prod_neg)
  );

  assign prod_mag = signed'(prod[DW-1:0]);
  assign prod_val = prod_neg ? -prod_mag : prod_mag;

  cbht_diff u_diff_x (
    .clk     (clk),
    .ctl     (ctl.diff_x),
    .a3      (a3x),
    .prod_val(prod_val),
    .d       (x_d)
  );

  cbht_diff u_diff_y (
    .clk     (clk),
    .ctl     (ctl.diff_y),
    .a3      (a3y),
    .prod_val(prod_val),
    .d       (y_d)
  );

  // Squares are built from the high-high, high-low (doubled) and low-low
  // partial products of the magnitude register; the same accumulator first
  // forms the squared scaled tolerance and then each squared distance.
  always_comb begin
    case (ctl.acc_sel)
      ACC_CLEAR: acc_next = '0;
      ACC_HH:    acc_next = acc + (AW'(prod) << SH_HH);
      ACC_HL:    acc_next = acc + (AW'(prod) << SH_HL);
      ACC_LL:    acc_next = acc + AW'(prod);
      default:   acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    case (ctl.mag_sel)
      MAG_PROD: mag <= prod[MW-1:0];
      MAG_DX:   mag <= mag_d(x_d);
      MAG_DY:   mag <= mag_d(y_d);
      default:  mag <= mag;
    endcase
    if (ctl.lim_ld) begin
      limit <= acc;
    end
    if (ctl.res_ld) begin
      hit <= hit_cond;
    end
  end

  assign hit_cond = (acc <= limit);

`ifndef SYNTHESIS
  // Once a word is taken the block is busy for at least the setup sequence.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again straight after a word was taken");

  // Every x offset that reaches the squaring step must fit the magnitude register.
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    ctl.mag_sel == MAG_DX |-> (x_d[DW-1:MW] == '0) || (x_d[DW-1:MW] == '1))
    else $error("x offset out of range at squaring");

  // A result appears only through the sequencer's final sample step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.res_ld))
    else $error("output valid raised without a result load");
`endif

endmodule

[verif/cubic_bezier_hit_test_checker.sv]
// Checker for the cubic Bezier hit test: predicts the hit flag of each query word and compares.
`timescale 1ns / 1ps

module cubic_bezier_hit_test_checker #(
  parameter int NUM_STEPS = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] first_ctrl_x,
  input  logic signed [15:0] first_ctrl_y,
  input  logic signed [15:0] second_ctrl_x,
  input  logic signed [15:0] second_ctrl_y,
  input  logic signed [15:0] finish_x,
  input  logic signed [15:0] finish_y,
  input  logic        [14:0] tolerance,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               hit,
  output int                 mismatches,
  output int                 expected_left,
  output int                 results_seen,
  output int                 hits_seen
);

  logic hit_expected_q[$];
  logic hit_wanted;

  // Samples the curve at t = k/N, all kept scaled by N cubed, and tests the squared
  // distance to the query point against the squared scaled tolerance, exactly.
  function automatic logic curve_passes_near(
    input logic signed [15:0] px, input logic signed [15:0] py,
    input logic signed [15:0] x0, input logic signed [15:0] y0,
    input logic signed [15:0] x1, input logic signed [15:0] y1,
    input logic signed [15:0] x2, input logic signed [15:0] y2,
    input logic signed [15:0] x3, input logic signed [15:0] y3,
    input logic [14:0] tol
  );
    longint       cube, qx, qy, rest, w0, w1, w2, w3, sx, sy, dx, dy;
    logic [127:0] reach, mx, my;
    logic         found;
    cube  = longint'(NUM_STEPS) * NUM_STEPS * NUM_STEPS;
    qx    = cube * px;
    qy    = cube * py;
    reach = 128'(cube * longint'(tol));
    reach = reach * reach;
    found = 1'b0;
    for (longint k = 0; k <= NUM_STEPS && !found; k++) begin
      rest = NUM_STEPS - k;
      w0   = rest * rest * rest;
      w1   = 3 * k * rest * rest;
      w2   = 3 * k * k * rest;
      w3   = k * k * k;
      sx   = w0 * x0 + w1 * x1 + w2 * x2 + w3 * x3;
      sy   = w0 * y0 + w1 * y1 + w2 * y2 + w3 * y3;
      dx   = sx - qx;
      dy   = sy - qy;
      mx   = 128'(dx < 0 ? -dx : dx);
      my   = 128'(dy < 0 ? -dy : dy);
      if (mx * mx + my * my <= reach) begin
        found = 1'b1;
      end
    end
    return found;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mismatches    <= 0;
      expected_left <= 0;
      results_seen  <= 0;
      hits_seen     <= 0;
    end else begin
      if (in_valid && in_ready) begin
        hit_expected_q.push_back(curve_passes_near(point_x, point_y, start_x, start_y,
                                                   first_ctrl_x, first_ctrl_y,
                                                   second_ctrl_x, second_ctrl_y,
                                                   finish_x, finish_y, tolerance));
      end
      if (out_valid && out_ready) begin
        if (hit_expected_q.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t: result word with no query waiting, expected none, actual hit=%0b",
                   $time, hit);
        end else begin
          hit_wanted = hit_expected_q.pop_front();
          results_seen <= results_seen + 1;
          if (hit === 1'b1) begin
            hits_seen <= hits_seen + 1;
          end
          if (hit !== hit_wanted) begin
            mismatches <= mismatches + 1;
            $display("%0t: hit mismatch, expected %0b, actual %0b", $time, hit_wanted, hit);
          end
        end
      end
      expected_left <= hit_expected_q.size();
    end
  end

endmodule

[verif/cubic_bezier_hit_test_tb.sv]
// Testbench top for the cubic Bezier hit test: stimulus, output idling and the verdict.
`timescale 1ns / 1ps

module cubic_bezier_hit_test_tb;

  localparam int NUM_STEPS      = 100;
  localparam int RANDOM_WORDS   = 1000;
  // The slowest correct run has every word missing and so walking all samples, with
  // the longest gaps on both sides; this limit leaves a wide margin over it.
  localparam int TIMEOUT_CYCLES = 5_000_000;
  // The long output hold-off, long enough for the block to fill.
  localparam int HOLD_CYCLES    = 3000;

  // One query word, kept together so that a word is built before it is offered.
  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic signed [15:0] x3;
    logic signed [15:0] y3;
    logic        [14:0] tol;
  } bezier_query_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic signed [15:0] point_x       = '0;
  logic signed [15:0] point_y       = '0;
  logic signed [15:0] start_x       = '0;
  logic signed [15:0] start_y       = '0;
  logic signed [15:0] first_ctrl_x  = '0;
  logic signed [15:0] first_ctrl_y  = '0;
  logic signed [15:0] second_ctrl_x = '0;
  logic signed [15:0] second_ctrl_y = '0;
  logic signed [15:0] finish_x      = '0;
  logic signed [15:0] finish_y      = '0;
  logic        [14:0] tolerance     = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic               hit;

  int mismatches;
  int expected_left;
  int results_seen;
  int hits_seen;

  int words_accepted = 0;
  int words_directed = 0;
  int cycle_count    = 0;
  // When set, neither side idles; used for a stretch in the middle and for the tail.
  bit idle_off       = 1'b0;
  bit hold_done      = 1'b0;

  cubic_bezier_hit_test #(
    .NUM_STEPS(NUM_STEPS)
  ) DUT (
    .*
  );

  cubic_bezier_hit_test_checker #(
    .NUM_STEPS(NUM_STEPS)
  ) hit_checker (
    .*
  );

  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("cubic_bezier_hit_test regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      words_accepted <= words_accepted + 1;
    end
  end

  // Packs one query from plain integers; out-of-range values simply wrap to the port width.
  function automatic bezier_query_t make_query(int px, int py, int x0, int y0, int x1, int y1,
                                               int x2, int y2, int x3, int y3, int tol);
    bezier_query_t q;
    q.px  = 16'(px);
    q.py  = 16'(py);
    q.x0  = 16'(x0);
    q.y0  = 16'(y0);
    q.x1  = 16'(x1);
    q.y1  = 16'(y1);
    q.x2  = 16'(x2);
    q.y2  = 16'(y2);
    q.x3  = 16'(x3);
    q.y3  = 16'(y3);
    q.tol = 15'(tol);
    return q;
  endfunction

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  // A coordinate over the whole range, or from a small window around the origin so that
  // curve, point and tolerance are of comparable size.
  function automatic int rand_coord(bit wide);
    return wide ? int'($signed(16'($urandom))) : $urandom_range(0, 4000) - 2000;
  endfunction

  // Half the words are placed so that the point sits near the curve, with a tolerance of the
  // same order as the offset, so that hits occur at many different samples. The rest are
  // degenerate curves and random points with random tolerances, some over the full ranges.
  function automatic bezier_query_t make_random_query();
    int kind, anchor, ax, ay, tol;
    bit wide;
    int c[8];
    kind = $urandom_range(0, 9);
    wide = $urandom_range(0, 1);
    foreach (c[i]) begin
      c[i] = rand_coord(wide);
    end
    if (kind <= 1) begin
      return make_query($urandom, $urandom, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
                        $urandom);
    end else if (kind <= 6) begin
      anchor = $urandom_range(0, 3);
      case (anchor)
        0: begin
          ax = c[0];
          ay = c[1];
        end
        1: begin
          ax = c[6];
          ay = c[7];
        end
        2: begin
          // The curve at t = 1/2.
          ax = (c[0] + 3 * c[2] + 3 * c[4] + c[6]) / 8;
          ay = (c[1] + 3 * c[3] + 3 * c[5] + c[7]) / 8;
        end
        default: begin
          // Centre of the control polygon; usually off the curve.
          ax = (c[0] + c[2] + c[4] + c[6]) / 4;
          ay = (c[1] + c[3] + c[5] + c[7]) / 4;
        end
      endcase
      ax  = clamp16(ax + $urandom_range(0, 128) - 64);
      ay  = clamp16(ay + $urandom_range(0, 128) - 64);
      tol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 200);
      return make_query(ax, ay, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], tol);
    end else if (kind == 7) begin
      ax = clamp16(c[0] + $urandom_range(0, 16) - 8);
      ay = clamp16(c[1] + $urandom_range(0, 16) - 8);
      return make_query(ax, ay, c[0], c[1], c[0], c[1], c[0], c[1], c[0], c[1],
                        $urandom_range(0, 12));
    end else begin
      return make_query(rand_coord(wide), rand_coord(wide), c[0], c[1], c[2], c[3], c[4],
                        c[5], c[6], c[7], $urandom_range(0, 32767));
    end
  endfunction

  // Offers one word and holds it until the block takes it. Called at a rising edge; returns
  // at the edge of acceptance, or after an optional idle burst on the input side after it.
  task automatic send_query(input bezier_query_t q);
    point_x       <= q.px;
    point_y       <= q.py;
    start_x       <= q.x0;
    start_y       <= q.y0;
    first_ctrl_x  <= q.x1;
    first_ctrl_y  <= q.y1;
    second_ctrl_x <= q.x2;
    second_ctrl_y <= q.y2;
    finish_x      <= q.x3;
    finish_y      <= q.y3;
    tolerance     <= q.tol;
    in_valid      <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Output side. Ready comes in random bursts, except for one long hold-off early in the
  // random part, during which the block keeps one result waiting, finishes the next and
  // then has to stall its input while the sender keeps offering.
  initial begin
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      if (!hold_done && words_accepted >= 40) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_off) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  initial begin
    bezier_query_t directed_q[$];

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Degenerate curves: every sample is the same point, including at the field extremes.
    directed_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768, -32768, 0));
    directed_q.push_back(make_query(-32768, -32768, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767, 32767, 32767));
    // A tolerance of exactly the distance counts as near; a point on the diagonal beyond it does not.
    directed_q.push_back(make_query(32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32767));
    directed_q.push_back(make_query(32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 32767));
    // Evenly spaced controls on a line give samples at x = 3k exactly.
    directed_q.push_back(make_query(150, 0, 0, 0, 100, 0, 200, 0, 300, 0, 0));
    directed_q.push_back(make_query(1, 0, 0, 0, 100, 0, 200, 0, 300, 0, 0));
    directed_q.push_back(make_query(1, 0, 0, 0, 100, 0, 200, 0, 300, 0, 1));
    directed_q.push_back(make_query(1, 1, 0, 0, 100, 0, 200, 0, 300, 0, 1));
    directed_q.push_back(make_query(0, 0, 0, 0, 100, 0, 200, 0, 300, 0, 0));
    directed_q.push_back(make_query(300, 0, 0, 0, 100, 0, 200, 0, 300, 0, 0));
    // Curve spanning the whole coordinate range, controls at opposite corners.
    directed_q.push_back(make_query(0, 0, -32768, -32768, 32767, -32768, -32768, 32767,
                                    32767, 32767, 32767));
    directed_q.push_back(make_query(0, 0, -32768, -32768, 32767, -32768, -32768, 32767,
                                    32767, 32767, 0));
    directed_q.push_back(make_query(-32768, 32767, -32768, -32768, 32767, -32768, -32768,
                                    32767, 32767, 32767, 0));
    directed_q.push_back(make_query(32767, 32767, -32768, -32768, 32767, -32768, -32768,
                                    32767, 32767, 32767, 0));
    // Zero tolerance on the start point of an irregular curve.
    directed_q.push_back(make_query(1234, -567, 1234, -567, -20000, 30000, 15000, -25000,
                                    7, 9, 0));
    // Symmetric arch: the middle sample lies exactly at (0, 1500).
    directed_q.push_back(make_query(0, 1500, -1000, 0, -1000, 2000, 1000, 2000, 1000, 0, 0));
    directed_q.push_back(make_query(0, 1501, -1000, 0, -1000, 2000, 1000, 2000, 1000, 0, 0));
    directed_q.push_back(make_query(0, 1600, -1000, 0, -1000, 2000, 1000, 2000, 1000, 0,
                                    100));
    directed_q.push_back(make_query(0, 1600, -1000, 0, -1000, 2000, 1000, 2000, 1000, 0,
                                    99));

    words_directed = directed_q.size();
    foreach (directed_q[i]) begin
      send_query(directed_q[i]);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      idle_off = (i >= 400 && i < 500) || (i >= RANDOM_WORDS - 120);
      send_query(make_random_query());
    end
    in_valid <= 1'b0;

    // One edge so that the last accepted word is counted by the checker.
    @(posedge clk);
    while (expected_left != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    $display("Covered %0d query words (%0d directed, %0d random): %0d results checked, %0d hits.",
             words_accepted, words_directed, RANDOM_WORDS, results_seen, hits_seen);
    $display("Idle bursts on both sides, one %0d-cycle output hold-off, no idling at the end.",
             HOLD_CYCLES);
    if (mismatches == 0 && expected_left == 0) begin
      $display("cubic_bezier_hit_test regression: pass");
    end else begin
      $display("cubic_bezier_hit_test regression: fail");
    end
    $finish;
  end

endmodule
